>>> rtl/gdc_pkg.sv
package gdc_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned CENT_W  = 8;    // year / 100, up to 163
    localparam int unsigned YOC_W   = 7;    // year % 100
    localparam int unsigned SUM_W   = 15;   // weekday sum before mod 7

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [WDAY_W-1:0]  wday_t;
    typedef logic [CENT_W-1:0]  cent_t;
    typedef logic [YOC_W-1:0]   yoc_t;
    typedef logic [SUM_W-1:0]   sum_t;

    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_FWD  = 2'd1;
    localparam op_t OP_BACK = 2'd2;

    localparam year_t  MAX_YEAR  = 14'd9999;
    localparam year_t  MIN_YEAR  = 14'd1;
    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;
    localparam day_t   DAY_FIRST = 5'd1;
    localparam day_t   DAY_DEC31 = 5'd31;
    localparam yoc_t   YOC_LAST  = 7'd99;

    // reset date 2024-01-01, Monday
    localparam year_t  RST_YEAR  = 14'd2024;
    localparam cent_t  RST_CENT  = 8'd20;
    localparam yoc_t   RST_YOC   = 7'd24;
    localparam month_t RST_MONTH = 4'd1;
    localparam day_t   RST_DAY   = 5'd1;
    localparam wday_t  RST_WDAY  = 3'd1;

    // floor(y / 100) = (y * 5243) >> 19, exact for 14-bit y
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = YEAR_W + 13;

    typedef struct packed {
        logic capture;  // latch load fields
        logic step;     // apply forward/back/no-op to state, load output word
        logic ld_cent;  // century quotient stage
        logic ld_yoc;   // year-of-century stage
        logic ld_sum;   // validity and weekday sum stage
        logic commit;   // mod 7, update state, load output word
    } gdc_cmd_t;

    typedef struct packed {
        logic is_load;
    } gdc_sts_t;

    function automatic logic is_leap(input cent_t cent, input yoc_t yoc);
        return (yoc[1:0] == 2'd0) && ((yoc != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic day_t days_in_month(input month_t m, input logic leap);
        day_t d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // month term of the weekday sum, reference offset folded in, mod 7
    function automatic wday_t month_offset(input month_t m);
        wday_t k;
        unique case (m)
            4'd1:    k = 3'd0;
            4'd2:    k = 3'd3;
            4'd3:    k = 3'd2;
            4'd4:    k = 3'd5;
            4'd5:    k = 3'd0;
            4'd6:    k = 3'd3;
            4'd7:    k = 3'd5;
            4'd8:    k = 3'd1;
            4'd9:    k = 3'd4;
            4'd10:   k = 3'd6;
            4'd11:   k = 3'd2;
            4'd12:   k = 3'd4;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    // 8 == 1 mod 7: fold octal digits, then one trim
    function automatic wday_t mod7(input sum_t s);
        logic [5:0] a;
        logic [3:0] b;
        a = '0;
        for (int i = 0; i < SUM_W / 3; i++) begin
            a = a + 6'(s[3*i +: 3]);
        end
        b = 4'(a[5:3]) + 4'(a[2:0]);
        if (b >= 4'd7) begin
            b = b - 4'd7;
        end
        return b[WDAY_W-1:0];
    endfunction

endpackage

>>> rtl/gdc_ctrl.sv
module gdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  gdc_pkg::gdc_sts_t sts,
    output gdc_pkg::gdc_cmd_t cmd
);
    import gdc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENT   = 3'd1;
    localparam logic [2:0] ST_YOC    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sts.is_load) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_CENT;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_CENT: begin
                cmd.ld_cent = 1'b1;
                state_next  = ST_YOC;
            end
            ST_YOC: begin
                cmd.ld_yoc = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_sum = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.step || cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || cmd.commit) |-> (!m_valid_reg || m_tready))
        else $error("output word overwritten before taken");

    a_capture_starts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_CENT))
        else $error("load sequence did not start");

    a_commit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !out_free) |=> (state_reg == ST_COMMIT))
        else $error("load result dropped while output busy");

endmodule

>>> rtl/gdc_dp.sv
module gdc_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  gdc_pkg::gdc_cmd_t   cmd,
    output gdc_pkg::gdc_sts_t   sts,
    input  gdc_pkg::op_t        in_op,
    input  gdc_pkg::year_t      in_year,
    input  gdc_pkg::month_t     in_month,
    input  gdc_pkg::day_t       in_day,
    output gdc_pkg::year_t      out_year,
    output gdc_pkg::month_t     out_month,
    output gdc_pkg::day_t       out_day,
    output gdc_pkg::wday_t      out_wday,
    output logic                out_ok
);
    import gdc_pkg::*;

    // current date, with year split into century and year-of-century
    year_t  cur_year_reg,  cur_year_next;
    cent_t  cur_cent_reg,  cur_cent_next;
    yoc_t   cur_yoc_reg,   cur_yoc_next;
    month_t cur_month_reg, cur_month_next;
    day_t   cur_day_reg,   cur_day_next;
    wday_t  cur_wday_reg,  cur_wday_next;
    logic   ok_next;

    // load pipeline
    year_t  ld_year_reg;
    month_t ld_month_reg;
    day_t   ld_day_reg;
    cent_t  ld_cent_reg;
    yoc_t   ld_yoc_reg;
    sum_t   ld_sum_reg;
    logic   ld_ok_reg;

    // output word
    year_t  o_year_reg;
    month_t o_month_reg;
    day_t   o_day_reg;
    wday_t  o_wday_reg;
    logic   o_ok_reg;

    logic              leap_cur;
    day_t              dim_cur;
    day_t              dim_prev;
    logic              at_last;
    logic              at_first;
    logic [PROD_W-1:0] cent_prod;
    year_t             cent_ext;
    year_t             cent_x100;
    logic              ld_leap;
    logic              ld_valid;
    year_t             yy;
    cent_t             yy_cent;
    sum_t              ld_sum;

    assign sts.is_load = (in_op == OP_LOAD);

    assign leap_cur = is_leap(cur_cent_reg, cur_yoc_reg);
    assign dim_cur  = days_in_month(cur_month_reg, leap_cur);
    assign dim_prev = days_in_month(cur_month_reg - 4'd1, leap_cur);
    assign at_last  = (cur_year_reg >= MAX_YEAR) && (cur_month_reg == MONTH_DEC)
                      && (cur_day_reg == DAY_DEC31);
    assign at_first = (cur_year_reg <= MIN_YEAR) && (cur_month_reg == MONTH_JAN)
                      && (cur_day_reg == DAY_FIRST);

    // load stages
    assign cent_prod = PROD_W'(ld_year_reg) * PROD_W'(RECIP_100);
    // century * 100 as 64 + 32 + 4, fits 14 bits for every century up to 163
    assign cent_ext  = YEAR_W'(ld_cent_reg);
    assign cent_x100 = (cent_ext << 6) + (cent_ext << 5) + (cent_ext << 2);
    assign ld_leap   = is_leap(ld_cent_reg, ld_yoc_reg);
    assign ld_valid  = (ld_year_reg >= MIN_YEAR) && (ld_year_reg <= MAX_YEAR)
                       && (ld_month_reg >= MONTH_JAN) && (ld_month_reg <= MONTH_DEC)
                       && (ld_day_reg >= DAY_FIRST)
                       && (ld_day_reg <= days_in_month(ld_month_reg, ld_leap));

    // Jan and Feb count with the previous year
    always_comb begin
        if (ld_month_reg <= MONTH_FEB) begin
            yy      = ld_year_reg - 14'd1;
            yy_cent = (ld_yoc_reg == '0) ? ld_cent_reg - 8'd1 : ld_cent_reg;
        end else begin
            yy      = ld_year_reg;
            yy_cent = ld_cent_reg;
        end
    end

    assign ld_sum = SUM_W'(yy) + SUM_W'(yy >> 2) - SUM_W'(yy_cent) + SUM_W'(yy_cent >> 2)
                    + SUM_W'(ld_day_reg) + SUM_W'(month_offset(ld_month_reg));

    always_comb begin
        cur_year_next  = cur_year_reg;
        cur_cent_next  = cur_cent_reg;
        cur_yoc_next   = cur_yoc_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        cur_wday_next  = cur_wday_reg;
        ok_next        = 1'b0;
        if (cmd.step) begin
            unique case (in_op)
                OP_FWD: begin
                    if (!at_last) begin
                        if (cur_day_reg >= dim_cur) begin
                            cur_day_next = DAY_FIRST;
                            if (cur_month_reg >= MONTH_DEC) begin
                                cur_month_next = MONTH_JAN;
                                cur_year_next  = cur_year_reg + 14'd1;
                                if (cur_yoc_reg == YOC_LAST) begin
                                    cur_yoc_next  = '0;
                                    cur_cent_next = cur_cent_reg + 8'd1;
                                end else begin
                                    cur_yoc_next = cur_yoc_reg + 7'd1;
                                end
                            end else begin
                                cur_month_next = cur_month_reg + 4'd1;
                            end
                        end else begin
                            cur_day_next = cur_day_reg + 5'd1;
                        end
                        cur_wday_next = (cur_wday_reg == 3'd6) ? 3'd0 : cur_wday_reg + 3'd1;
                        ok_next       = 1'b1;
                    end
                end
                OP_BACK: begin
                    if (!at_first) begin
                        if (cur_day_reg <= DAY_FIRST) begin
                            if (cur_month_reg <= MONTH_JAN) begin
                                cur_month_next = MONTH_DEC;
                                cur_day_next   = DAY_DEC31;
                                cur_year_next  = cur_year_reg - 14'd1;
                                if (cur_yoc_reg == '0) begin
                                    cur_yoc_next  = YOC_LAST;
                                    cur_cent_next = cur_cent_reg - 8'd1;
                                end else begin
                                    cur_yoc_next = cur_yoc_reg - 7'd1;
                                end
                            end else begin
                                cur_month_next = cur_month_reg - 4'd1;
                                cur_day_next   = dim_prev;
                            end
                        end else begin
                            cur_day_next = cur_day_reg - 5'd1;
                        end
                        cur_wday_next = (cur_wday_reg == 3'd0) ? 3'd6 : cur_wday_reg - 3'd1;
                        ok_next       = 1'b1;
                    end
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
        end else if (cmd.commit && ld_ok_reg) begin
            cur_year_next  = ld_year_reg;
            cur_cent_next  = ld_cent_reg;
            cur_yoc_next   = ld_yoc_reg;
            cur_month_next = ld_month_reg;
            cur_day_next   = ld_day_reg;
            cur_wday_next  = mod7(ld_sum_reg);
            ok_next        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_year_reg  <= RST_YEAR;
            cur_cent_reg  <= RST_CENT;
            cur_yoc_reg   <= RST_YOC;
            cur_month_reg <= RST_MONTH;
            cur_day_reg   <= RST_DAY;
            cur_wday_reg  <= RST_WDAY;
        end else begin
            cur_year_reg  <= cur_year_next;
            cur_cent_reg  <= cur_cent_next;
            cur_yoc_reg   <= cur_yoc_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            cur_wday_reg  <= cur_wday_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ld_year_reg  <= in_year;
            ld_month_reg <= in_month;
            ld_day_reg   <= in_day;
        end
        if (cmd.ld_cent) begin
            ld_cent_reg <= cent_prod[RECIP_SHIFT +: CENT_W];
        end
        if (cmd.ld_yoc) begin
            ld_yoc_reg <= YOC_W'(ld_year_reg - cent_x100);
        end
        if (cmd.ld_sum) begin
            ld_sum_reg <= ld_sum;
            ld_ok_reg  <= ld_valid;
        end
        if (cmd.step || cmd.commit) begin
            o_year_reg  <= cur_year_next;
            o_month_reg <= cur_month_next;
            o_day_reg   <= cur_day_next;
            o_wday_reg  <= cur_wday_next;
            o_ok_reg    <= ok_next;
        end
    end

    assign out_year  = o_year_reg;
    assign out_month = o_month_reg;
    assign out_day   = o_day_reg;
    assign out_wday  = o_wday_reg;
    assign out_ok    = o_ok_reg;

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_DEC))
        else $error("current month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_day_reg >= DAY_FIRST) && (cur_day_reg <= dim_cur))
        else $error("current day beyond month length");

    a_year_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_yoc_reg <= YOC_LAST)
        && (cur_year_reg == YEAR_W'(cur_cent_reg) * 14'd100 + YEAR_W'(cur_yoc_reg)))
        else $error("century counters disagree with year");

endmodule

>>> rtl/gregorian_date_counter_core.sv
// Proleptic Gregorian date counter with weekday, reset to 2024-01-01 (Monday). Each input
// word carries op (0 load date, 1 step one day forward, 2 step one day back, 3 no-op) and,
// for a load, year/month/day; each input word returns exactly one output word with the
// date and weekday (0 Sunday .. 6 Saturday) held afterward plus an ok flag. An invalid
// load (year 0 or above 9999, bad month, day 0 or past month end), a step off either end
// of the year range, or op 3 leaves the date as it was and returns ok = 0. Steps and
// no-ops are done in the accept cycle: the output word is valid on the next cycle, and
// with m_axis_tready high a new word is taken every cycle. A load walks a four-stage
// sequence (century quotient by reciprocal multiply, year of century, validity and
// weekday sum, mod 7 and commit): commit waits until the output word is free, and the
// next word is taken only after the sequence has returned to idle. The input is held
// off only while a load is in flight or the output word has not been taken.
module gregorian_date_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[1:0], year_in[15:2], month_in[19:16],
                                        // day_in[24:20], zero pad [31:25]
    // output words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // year_out[13:0], month_out[17:14], day_out[22:18],
                                        // weekday_out[25:23], ok[26], zero pad [31:27]
);
    import gdc_pkg::*;

    gdc_cmd_t cmd;
    gdc_sts_t sts;

    year_t  out_year;
    month_t out_month;
    day_t   out_day;
    wday_t  out_wday;
    logic   out_ok;

    // sequencer: handshakes and load stages
    gdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // date state, step logic, load pipeline and output word
    gdc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_axis_tdata[1:0]),
        .in_year   (s_axis_tdata[15:2]),
        .in_month  (s_axis_tdata[19:16]),
        .in_day    (s_axis_tdata[24:20]),
        .out_year  (out_year),
        .out_month (out_month),
        .out_day   (out_day),
        .out_wday  (out_wday),
        .out_ok    (out_ok)
    );

    assign m_axis_tdata = {5'b0, out_ok, out_wday, out_day, out_month, out_year};

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdc_pkg::*;

    // op code with no action; the package names only the three live ones
    localparam op_t OP_NONE = 2'd3;

    localparam int unsigned ITEM_TARGET  = 1100;
    localparam int unsigned HOLD_START   = 300;   // words in before the long stall
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 20;    // load is 4 deep, plenty of margin
    localparam int unsigned MAX_REPORTS  = 10;

    // input word layout, lowest bits first: op, year, month, day, pad
    typedef struct packed {
        logic [6:0] pad;
        day_t       day;
        month_t     month;
        year_t      year;
        op_t        op;
    } req_word_t;

    // output word layout, lowest bits first: year, month, day, weekday, ok, pad
    typedef struct packed {
        logic [4:0] pad;
        logic       ok;
        wday_t      wday;
        day_t       day;
        month_t     month;
        year_t      year;
    } date_word_t;

    // Calendar tracker: keeps its own copy of the date and queues the word
    // that each accepted request should produce.
    class date_tracker;
        year_t       year;
        month_t      month;
        day_t        day;
        wday_t       wday;
        date_word_t  due_dates[$];
        int unsigned errors;
        int unsigned n_load_ok, n_load_bad, n_steps, n_held, n_nop;

        function new();
            year       = RST_YEAR;
            month      = RST_MONTH;
            day        = RST_DAY;
            wday       = RST_WDAY;
            errors     = 0;
            n_load_ok  = 0;
            n_load_bad = 0;
            n_steps    = 0;
            n_held     = 0;
            n_nop      = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        static function int unsigned month_days(int unsigned y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // days since 0000-03-01, March-based year so leap day falls last
        static function int unsigned day_count(int unsigned y, int unsigned m,
                                               int unsigned d);
            int unsigned yy, era, yoe, mp, doy;
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m + 9) % 12;
            doy = (153 * mp + 2) / 5 + d - 1;
            return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
        endfunction

        // weekday relative to 2024-01-01, which is a Monday
        static function wday_t weekday_for(int unsigned y, int unsigned m, int unsigned d);
            int unsigned anchor, n;
            anchor = day_count(2024, 1, 1) % 7;
            n      = day_count(y, m, d) % 7;
            return wday_t'((n + 7 - anchor + 1) % 7);
        endfunction

        function void apply_op(req_word_t r);
            date_word_t e;
            logic       ok;
            ok = 1'b0;
            case (r.op)
                OP_LOAD: begin
                    if (r.year >= 1 && r.year <= MAX_YEAR && r.month >= 1 && r.month <= 12 &&
                        r.day >= 1 && r.day <= month_days(r.year, r.month)) begin
                        year  = r.year;
                        month = r.month;
                        day   = r.day;
                        wday  = weekday_for(r.year, r.month, r.day);
                        ok    = 1'b1;
                        n_load_ok++;
                    end else begin
                        n_load_bad++;
                    end
                end
                OP_FWD: begin
                    if (year >= MAX_YEAR && month == 12 && day == 31) begin
                        n_held++;
                    end else begin
                        if (day >= month_days(year, month)) begin
                            day = 1;
                            if (month >= 12) begin
                                month = 1;
                                year  = year + 1;
                            end else begin
                                month = month + 1;
                            end
                        end else begin
                            day = day + 1;
                        end
                        wday = (wday == 3'd6) ? 3'd0 : wday + 3'd1;
                        ok   = 1'b1;
                        n_steps++;
                    end
                end
                OP_BACK: begin
                    if (year <= 1 && month == 1 && day == 1) begin
                        n_held++;
                    end else begin
                        if (day <= 1) begin
                            if (month <= 1) begin
                                month = 12;
                                year  = year - 1;
                            end else begin
                                month = month - 1;
                            end
                            day = day_t'(month_days(year, month));
                        end else begin
                            day = day - 1;
                        end
                        wday = (wday == 3'd0) ? 3'd6 : wday - 3'd1;
                        ok   = 1'b1;
                        n_steps++;
                    end
                end
                default: begin
                    n_nop++;
                end
            endcase
            e       = '0;
            e.year  = year;
            e.month = month;
            e.day   = day;
            e.wday  = wday;
            e.ok    = ok;
            due_dates.push_back(e);
        endfunction

        function void compare_date(date_word_t got);
            date_word_t e;
            if (due_dates.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected date word: %0d-%0d-%0d wd %0d ok %0d",
                             got.year, got.month, got.day, got.wday, got.ok);
                return;
            end
            e = due_dates.pop_front();
            if (got.year !== e.year || got.month !== e.month || got.day !== e.day ||
                got.wday !== e.wday || got.ok !== e.ok) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("date word mismatch: expected %0d-%0d-%0d wd %0d ok %0d, got %0d-%0d-%0d wd %0d ok %0d",
                             e.year, e.month, e.day, e.wday, e.ok,
                             got.year, got.month, got.day, got.wday, got.ok);
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // op, year_in, month_in, day_in, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // year_out, month_out, day_out, weekday_out, ok, pad

    date_tracker sb;
    int unsigned accepted_in = 0;      // words taken by the block
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    bit          hold_rx     = 1'b0;   // long receiver stall in progress

    gregorian_date_counter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both handshakes are sampled here at the rising edge; inputs only move
    // on the falling edge, so these reads never race the drivers.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.apply_op(req_word_t'(s_axis_tdata));
                accepted_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.compare_date(date_word_t'(m_axis_tdata));
            end
        end
    end

    // Sender: one word per call, grouped into bursts with random gaps.
    // Called and returns on a falling edge. tvalid stays high across a burst and
    // is dropped only for the gap before a new burst.
    task automatic send_req(input op_t op, input int unsigned y, input int unsigned m,
                            input int unsigned d);
        req_word_t r;
        r       = '0;
        r.op    = op;
        r.year  = year_t'(y);
        r.month = month_t'(m);
        r.day   = day_t'(d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tdata  <= r;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // day steps ignore the date fields, so fill them with garbage
    task automatic step_req(input op_t op);
        send_req(op, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    endtask

    // A valid load biased toward the interesting corners (range ends, century
    // and 400-year leap rules, month ends), then a short run of day steps.
    task automatic load_session();
        int unsigned y, m, d, ml, n, dir;
        case ($urandom_range(0, 7))
            0:       y = $urandom_range(1, 3);
            1:       y = $urandom_range(9997, 9999);
            2:       y = 100 * $urandom_range(1, 99);
            3:       y = 400 * $urandom_range(1, 24);
            4:       y = 4 * $urandom_range(1, 2499);
            default: y = $urandom_range(1, 9999);
        endcase
        case ($urandom_range(0, 9))
            0, 1:    m = 2;
            2:       m = 1;
            3:       m = 12;
            default: m = $urandom_range(1, 12);
        endcase
        ml = date_tracker::month_days(y, m);
        case ($urandom_range(0, 3))
            0:       d = ml;
            1:       d = ml - 1;
            2:       d = 1;
            default: d = $urandom_range(1, ml);
        endcase
        send_req(OP_LOAD, y, m, d);
        n   = $urandom_range(1, 12);
        dir = $urandom_range(0, 2);
        repeat (n) begin
            if (dir == 0)
                step_req(OP_FWD);
            else if (dir == 1)
                step_req(OP_BACK);
            else
                step_req($urandom_range(0, 1) ? OP_FWD : OP_BACK);
        end
    endtask

    // noise: raw words, bad months, bad days, idle op
    task automatic noise_word();
        int unsigned y, m, ml;
        case ($urandom_range(0, 3))
            0: send_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 16383),
                        $urandom_range(0, 15), $urandom_range(0, 31));
            1: send_req(OP_LOAD, $urandom_range(1, 9999),
                        $urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
                        $urandom_range(0, 31));
            2: begin
                y  = $urandom_range(1, 9999);
                m  = $urandom_range(1, 12);
                ml = date_tracker::month_days(y, m);
                send_req(OP_LOAD, y, m, (ml == 31) ? 0 : $urandom_range(ml + 1, 31));
            end
            default: step_req(OP_NONE);
        endcase
    endtask

    // Receiver: a stall pattern that switches to a randomly chosen mode whenever the last one runs out:
    // always ready, coin flip, ready when a running count is a multiple of k, mostly ready.
    initial begin : rx_stall
        int unsigned left, mode, k, cnt;
        bit          rdy;
        left = 0;
        mode = 0;
        k    = 2;
        cnt  = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
                k    = $urandom_range(2, 4);
            end
            left--;
            cnt++;
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (cnt % k) == 0;
                default: rdy = $urandom_range(0, 4) != 0;
            endcase
            m_axis_tready <= hold_rx ? 1'b0 : rdy;
        end
    end

    // Once, hold the output off long enough that the block backs up into
    // its input while the sender keeps offering words.
    initial begin : rx_long_hold
        while (accepted_in < HOLD_START) @(negedge aclk);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    initial begin : watchdog
        #3ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int unsigned failures;
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset date, leap rules, range ends, every kind of bad load
        step_req(OP_BACK);                    // 2023-12-31, Sunday
        step_req(OP_FWD);                     // back to the reset date
        send_req(OP_NONE, 16383, 15, 31);     // idle op, all field bits set
        send_req(OP_LOAD, 2000, 2, 29);       // 400-year leap day
        send_req(OP_LOAD, 1900, 2, 29);       // century year, no leap day
        send_req(OP_LOAD, 2100, 2, 28);
        step_req(OP_FWD);                     // 2100-03-01
        send_req(OP_LOAD, 9999, 12, 31);
        step_req(OP_FWD);                     // held at top of range
        step_req(OP_BACK);
        send_req(OP_LOAD, 1, 1, 1);
        step_req(OP_BACK);                    // held at bottom of range
        step_req(OP_FWD);
        send_req(OP_LOAD, 0, 5, 5);           // year zero
        send_req(OP_LOAD, 10000, 1, 1);       // year past range
        send_req(OP_LOAD, 16383, 12, 31);
        send_req(OP_LOAD, 2024, 0, 1);        // month zero
        send_req(OP_LOAD, 2024, 13, 1);
        send_req(OP_LOAD, 2024, 15, 31);
        send_req(OP_LOAD, 2023, 4, 31);       // day past month end
        send_req(OP_LOAD, 2023, 6, 0);        // day zero
        send_req(OP_LOAD, 2024, 2, 29);
        step_req(OP_FWD);                     // 2024-03-01
        send_req(OP_LOAD, 1, 3, 1);
        step_req(OP_BACK);                    // 0001-02-28

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 15)
                noise_word();
            else
                load_session();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.due_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        failures = sb.errors + sb.due_dates.size();
        $display("run covered %0d words: %0d good loads, %0d rejected loads, %0d day steps",
                 accepted_in, sb.n_load_ok, sb.n_load_bad, sb.n_steps);
        $display("  %0d steps held at the range ends, %0d idle ops, one %0d-cycle output stall",
                 sb.n_held, sb.n_nop, HOLD_CYCLES);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", failures);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/gdc_pkg.sv
rtl/gdc_ctrl.sv
rtl/gdc_dp.sv
rtl/gregorian_date_counter_core.sv
tb/sv/testbench.sv
